// File: sv/ordered_list_engine_with_sort_macros.svh
// assertion macros for the ordered list engine
`ifndef ORDERED_LIST_ENGINE_WITH_SORT_MACROS_SVH
`define ORDERED_LIST_ENGINE_WITH_SORT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define OLE_ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("ordered list engine assertion failed");
`define OLE_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("ordered list engine assertion failed");
`else
`define OLE_ASSERT_IMP(label, clk, rst, a, c)
`define OLE_ASSERT_NEXT(label, clk, rst, a, c)
`endif
`endif

// File: sv/ole_pkg.sv
// shared types and codes of the ordered list engine
package ole_pkg;
  typedef enum logic [3:0] {
    OP_PUSH_FRONT = 4'd0, OP_PUSH_BACK = 4'd1, OP_INSERT_AT = 4'd2,
    OP_INSERT_AFTER = 4'd3, OP_POP_FRONT = 4'd4, OP_POP_BACK = 4'd5,
    OP_DELETE_MATCH = 4'd6, OP_DELETE_AT = 4'd7, OP_SORT = 4'd8,
    OP_READ_OUT = 4'd9, OP_NOP_A = 4'd10, OP_NOP_B = 4'd11, OP_NOP_C = 4'd12,
    OP_NOP_D = 4'd13, OP_NOP_E = 4'd14, OP_NOP_F = 4'd15
  } op_t;
  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_FULL = 3'd1;
  localparam logic [2:0] ST_EMPTY = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_BADPOS = 3'd4;
  typedef struct packed {
    logic [3:0]  op;
    logic [31:0] data;
    logic [31:0] match_value;
    logic [6:0]  position;
  } cmd_t;
  typedef enum logic [3:0] {
    S_IDLE, S_SEARCH, S_DECIDE, S_SHIFT_UP, S_SHIFT_DN, S_SORT_RD, S_SORT_CMP,
    S_SORT_WR, S_EMIT, S_READ, S_RESULT
  } state_t;
endpackage

// File: sv/ole_front.sv
// front end: two-entry command queue
module ole_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  ole_pkg::cmd_t in_cmd,
  output logic          q_valid,
  input  logic          q_ready,
  output ole_pkg::cmd_t q_cmd
);
  import ole_pkg::*;
  cmd_t slot [2];
  logic rd_ptr, wr_ptr;
  logic [1:0] fill;
  logic push, pop;
  assign in_ready = fill != 2'd2;
  assign q_valid = fill != 2'd0;
  assign q_cmd = slot[rd_ptr];
  assign push = in_valid && in_ready;
  assign pop = q_valid && q_ready;
  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= in_cmd;
    if (rst) begin
      fill <= 2'd0; rd_ptr <= 1'b0; wr_ptr <= 1'b0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end
`include "ordered_list_engine_with_sort_macros.svh"
  `OLE_ASSERT_IMP(a_fill_bound, clk, rst, 1'b1, fill != 2'd3)
  `OLE_ASSERT_NEXT(a_fill_push, clk, rst, push && !pop, fill == $past(fill) + 2'd1)
  `OLE_ASSERT_NEXT(a_fill_pop, clk, rst, pop && !push, fill == $past(fill) - 2'd1)
endmodule

// File: sv/ole_back.sv
// back end: list store with search, shift, sort and read-out sequencer
module ole_back #(
  parameter int DEPTH = 32,
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_valid,
  output logic                  q_ready,
  input  ole_pkg::cmd_t         q_cmd,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [2:0]            status,
  output logic [DATA_WIDTH-1:0] element,
  output logic [6:0]            count,
  output logic                  last
);
  import ole_pkg::*;
  localparam int AW = $clog2(DEPTH);
  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rdata;
  state_t state, state_next;
  cmd_t cmd;
  logic [6:0] cnt, cnt_next;
  logic [6:0] idx, idx_next, jdx, jdx_next, tgt, tgt_next;
  logic [DATA_WIDTH-1:0] vi, vi_next, vj, vj_next;
  logic [DATA_WIDTH-1:0] dv, mv;
  logic [2:0] st, st_next;
  logic [6:0] ra;
  logic we;
  logic [6:0] wa;
  logic [DATA_WIDTH-1:0] wd;
  logic ovalid, ovalid_next;
  logic [DATA_WIDTH-1:0] oel, oel_next;
  logic olast, olast_next;
  logic [2:0] ost, ost_next;
  logic [6:0] ocnt, ocnt_next;
  logic out_free;
  logic rd_pending, rd_pending_next;

  assign dv = DATA_WIDTH'({{(64-32){q_cmd.data[31]}}, q_cmd.data});
  assign mv = DATA_WIDTH'({{(64-32){cmd.match_value[31]}}, cmd.match_value});
  assign out_free = !ovalid || out_ready;
  assign out_valid = ovalid;
  assign status = ost;
  assign element = oel;
  assign count = ocnt;
  assign last = olast;

  always_ff @(posedge clk) begin
    if (we) mem[wa[AW-1:0]] <= wd;
    rdata <= mem[ra[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; cnt <= 7'd0; ovalid <= 1'b0; rd_pending <= 1'b0;
    end else begin
      state <= state_next; cnt <= cnt_next; ovalid <= ovalid_next;
      rd_pending <= rd_pending_next;
    end
    if (state == S_IDLE && q_valid) begin
      cmd <= q_cmd;
      vi <= dv;
    end else begin
      vi <= vi_next;
    end
    idx <= idx_next; jdx <= jdx_next; tgt <= tgt_next; vj <= vj_next;
    st <= st_next; oel <= oel_next; olast <= olast_next; ost <= ost_next;
    ocnt <= ocnt_next;
  end

  always_comb begin
    state_next = state; cnt_next = cnt; idx_next = idx; jdx_next = jdx;
    tgt_next = tgt; vi_next = vi; vj_next = vj; st_next = st;
    ovalid_next = ovalid && !out_ready;
    oel_next = oel; olast_next = olast; ost_next = ost; ocnt_next = ocnt;
    rd_pending_next = 1'b0;
    q_ready = 1'b0; we = 1'b0; wa = idx; wd = vi; ra = idx;
    unique case (state)
      S_IDLE: begin
        q_ready = 1'b1;
        st_next = ST_OK; idx_next = 7'd0;
        if (q_valid) begin
          state_next = S_RESULT;
          unique case (op_t'(q_cmd.op))
            OP_PUSH_FRONT, OP_PUSH_BACK, OP_INSERT_AT: begin
              tgt_next = (op_t'(q_cmd.op) == OP_PUSH_FRONT) ? 7'd0 :
                         (op_t'(q_cmd.op) == OP_PUSH_BACK) ? cnt : q_cmd.position;
              if (cnt >= 7'(DEPTH)) st_next = ST_FULL;
              else if (op_t'(q_cmd.op) == OP_INSERT_AT && q_cmd.position > cnt)
                st_next = ST_BADPOS;
              else begin
                idx_next = cnt; state_next = S_SHIFT_UP;
              end
            end
            OP_INSERT_AFTER: begin
              if (cnt >= 7'(DEPTH)) st_next = ST_FULL;
              else if (cnt == 7'd0) st_next = ST_NOTFOUND;
              else state_next = S_SEARCH;
            end
            OP_POP_FRONT, OP_POP_BACK, OP_DELETE_AT: begin
              tgt_next = (op_t'(q_cmd.op) == OP_POP_FRONT) ? 7'd0 :
                         (op_t'(q_cmd.op) == OP_POP_BACK) ? cnt - 7'd1 : q_cmd.position;
              if (cnt == 7'd0) st_next = ST_EMPTY;
              else if (op_t'(q_cmd.op) == OP_DELETE_AT && q_cmd.position >= cnt)
                st_next = ST_BADPOS;
              else begin
                idx_next = (op_t'(q_cmd.op) == OP_POP_FRONT) ? 7'd0 :
                           (op_t'(q_cmd.op) == OP_POP_BACK) ? cnt - 7'd1 : q_cmd.position;
                state_next = S_SHIFT_DN;
              end
            end
            OP_DELETE_MATCH: begin
              if (cnt == 7'd0) st_next = ST_EMPTY;
              else state_next = S_SEARCH;
            end
            OP_SORT: begin
              if (cnt == 7'd0) st_next = ST_EMPTY;
              else begin
                idx_next = 7'd0; jdx_next = 7'd1; state_next = S_SORT_RD;
              end
            end
            OP_READ_OUT: begin
              if (cnt == 7'd0) st_next = ST_EMPTY;
              else state_next = S_READ;
            end
            default: ;
          endcase
        end
      end
      // sequential compare; read data lands in the cycle after the address
      S_SEARCH: begin
        ra = idx; state_next = S_DECIDE;
      end
      S_DECIDE: begin
        if (rdata == mv) begin
          if (op_t'(cmd.op) == OP_INSERT_AFTER) begin
            tgt_next = idx + 7'd1; idx_next = cnt; state_next = S_SHIFT_UP;
          end else begin
            tgt_next = idx; state_next = S_SHIFT_DN;
          end
        end else if (idx + 7'd1 >= cnt) begin
          st_next = ST_NOTFOUND; state_next = S_RESULT;
        end else begin
          idx_next = idx + 7'd1; state_next = S_SEARCH;
        end
      end
      // move entries up one slot from the back, then drop the new word in
      S_SHIFT_UP: begin
        if (idx == tgt) begin
          we = 1'b1; wa = tgt; wd = vi; cnt_next = cnt + 7'd1; state_next = S_RESULT;
        end else if (!rd_pending) begin
          ra = idx - 7'd1; rd_pending_next = 1'b1;
        end else begin
          we = 1'b1; wa = idx; wd = rdata; idx_next = idx - 7'd1;
        end
      end
      S_SHIFT_DN: begin
        if (idx + 7'd1 >= cnt) begin
          cnt_next = cnt - 7'd1; state_next = S_RESULT;
        end else if (!rd_pending) begin
          ra = idx + 7'd1; rd_pending_next = 1'b1;
        end else begin
          we = 1'b1; wa = idx; wd = rdata; idx_next = idx + 7'd1;
        end
      end
      S_SORT_RD: begin
        if (idx + 7'd1 >= cnt) state_next = S_RESULT;
        else if (jdx >= cnt) begin
          idx_next = idx + 7'd1; jdx_next = idx + 7'd2;
        end else begin
          ra = idx; state_next = S_SORT_CMP; rd_pending_next = 1'b0;
        end
      end
      S_SORT_CMP: begin
        if (!rd_pending) begin
          vi_next = rdata; ra = jdx; rd_pending_next = 1'b1;
        end else begin
          vj_next = rdata; state_next = S_SORT_WR;
        end
      end
      S_SORT_WR: begin
        if (!rd_pending && $signed(vi) > $signed(vj)) begin
          we = 1'b1; wa = idx; wd = vj; rd_pending_next = 1'b1;
        end else begin
          if (rd_pending) begin
            we = 1'b1; wa = jdx; wd = vi;
          end
          jdx_next = jdx + 7'd1; state_next = S_SORT_RD;
        end
      end
      S_READ: begin
        ra = idx; state_next = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          ovalid_next = 1'b1; ost_next = ST_OK; oel_next = rdata; ocnt_next = cnt;
          olast_next = (idx + 7'd1 == cnt);
          if (idx + 7'd1 == cnt) state_next = S_IDLE;
          else begin
            idx_next = idx + 7'd1; state_next = S_READ;
          end
        end
      end
      S_RESULT: begin
        if (out_free) begin
          ovalid_next = 1'b1; ost_next = st; oel_next = '0; ocnt_next = cnt;
          olast_next = 1'b1; state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end
`include "ordered_list_engine_with_sort_macros.svh"
  `OLE_ASSERT_IMP(a_cnt_bound, clk, rst, 1'b1, cnt <= 7'(DEPTH))
  `OLE_ASSERT_IMP(a_take_idle, clk, rst, q_ready, state == S_IDLE)
  `OLE_ASSERT_NEXT(a_cnt_step, clk, rst, state != S_IDLE,
    cnt == $past(cnt) || cnt == $past(cnt) + 7'd1 || cnt == $past(cnt) - 7'd1)
endmodule

// File: sv/ordered_list_engine_with_sort.sv
// top level of the ordered list engine
// channel | signals                             | dir
// in      | in_valid in_ready op data match_value position | in
// out     | out_valid out_ready status element count last | out
// an insert or delete walks the list once, searching or shifting one entry at a time
// read-out emits entries in turn, holding on a stall; sort swaps out-of-order signed pairs
// rst clears the count and the queue; the store itself is never cleared
// the two-entry queue takes beats while the back end works or output stalls, until full
module ordered_list_engine_with_sort #(
  parameter int DEPTH = 32,
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [3:0]            op,
  input  logic signed [31:0]    data,
  input  logic signed [31:0]    match_value,
  input  logic [6:0]            position,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [2:0]            status,
  output logic signed [DATA_WIDTH-1:0] element,
  output logic [6:0]            count,
  output logic                  last
);
  import ole_pkg::*;
  cmd_t in_cmd, q_cmd;
  logic q_valid, q_ready;
  logic [DATA_WIDTH-1:0] el;
  assign in_cmd = '{op: op, data: data, match_value: match_value, position: position};
  assign element = el;
  ole_front u_front (.clk, .rst, .in_valid, .in_ready, .in_cmd,
    .q_valid, .q_ready, .q_cmd);
  ole_back #(.DEPTH(DEPTH), .DATA_WIDTH(DATA_WIDTH)) u_back (.clk, .rst,
    .q_valid, .q_ready, .q_cmd, .out_valid, .out_ready, .status, .element(el),
    .count, .last);
endmodule

// File: tb/ordered_list_engine_with_sort_test.sv
// testbench for the ordered list engine: directed table, a fill to full, then random operations
module ordered_list_engine_with_sort_test;
  import ole_pkg::*;

  localparam int DEPTH = 32;
  localparam int CYCLE_LIMIT = 5000000;

  typedef struct {
    logic [3:0]  op;
    logic [31:0] data;
    logic [31:0] match_value;
    logic [6:0]  position;
    logic        known;
    logic [2:0]  status;
    logic [6:0]  count;
  } row_t;

  typedef struct {
    logic [2:0]  status;
    logic [31:0] element;
    logic [6:0]  count;
    logic        last;
  } beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [3:0] op = '0;
  logic signed [31:0] data = '0;
  logic signed [31:0] match_value = '0;
  logic [6:0] position = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [2:0] status;
  logic signed [31:0] element;
  logic [6:0] count;
  logic last;

  ordered_list_engine_with_sort #(.DEPTH(DEPTH), .DATA_WIDTH(32)) DUT (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // shadow copy of the list
  logic [31:0] shadow [DEPTH];
  int shadow_len = 0;
  beat_t expected_beats [$];
  int errors = 0;
  int cycles = 0;
  bit no_idle = 1'b0;
  int hold_off = 0;

  function automatic int find_value(logic [31:0] v);
    for (int i = 0; i < shadow_len; i++)
      if (shadow[i] == v) return i;
    return -1;
  endfunction

  function automatic void shadow_insert(int pos, logic [31:0] v);
    for (int i = shadow_len; i > pos; i--) shadow[i] = shadow[i-1];
    shadow[pos] = v;
    shadow_len++;
  endfunction

  function automatic void shadow_remove(int pos);
    for (int i = pos; i + 1 < shadow_len; i++) shadow[i] = shadow[i+1];
    shadow_len--;
  endfunction

  // applies one operation to the shadow list and queues the beats it causes
  function automatic void predict_list_op(logic [3:0] o, logic [31:0] d, logic [31:0] m,
                                          logic [6:0] p);
    logic [2:0] st;
    int w;
    logic [31:0] t;
    bit full;
    bit empty;
    st = ST_OK;
    full = shadow_len >= DEPTH;
    empty = shadow_len == 0;
    case (op_t'(o))
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (full) st = ST_FULL;
        else shadow_insert(o == OP_PUSH_FRONT ? 0 : shadow_len, d);
      end
      OP_INSERT_AT: begin
        if (full) st = ST_FULL;
        else if (p > shadow_len) st = ST_BADPOS;
        else shadow_insert(p, d);
      end
      OP_INSERT_AFTER: begin
        w = find_value(m);
        if (full) st = ST_FULL;
        else if (w < 0) st = ST_NOTFOUND;
        else shadow_insert(w + 1, d);
      end
      OP_POP_FRONT, OP_POP_BACK: begin
        if (empty) st = ST_EMPTY;
        else shadow_remove(o == OP_POP_FRONT ? 0 : shadow_len - 1);
      end
      OP_DELETE_MATCH: begin
        w = find_value(m);
        if (empty) st = ST_EMPTY;
        else if (w < 0) st = ST_NOTFOUND;
        else shadow_remove(w);
      end
      OP_DELETE_AT: begin
        if (empty) st = ST_EMPTY;
        else if (p >= shadow_len) st = ST_BADPOS;
        else shadow_remove(p);
      end
      OP_SORT: begin
        if (empty) st = ST_EMPTY;
        else
          for (int i = 0; i + 1 < shadow_len; i++)
            for (int j = i + 1; j < shadow_len; j++)
              if ($signed(shadow[i]) > $signed(shadow[j])) begin
                t = shadow[i]; shadow[i] = shadow[j]; shadow[j] = t;
              end
      end
      OP_READ_OUT: begin
        if (empty) st = ST_EMPTY;
        else begin
          for (int i = 0; i < shadow_len; i++)
            expected_beats.push_back('{ST_OK, shadow[i], 7'(shadow_len),
                                       i + 1 == shadow_len});
          return;
        end
      end
      default: ;
    endcase
    expected_beats.push_back('{st, 32'd0, 7'(shadow_len), 1'b1});
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return shadow_len > 0 ? shadow[$urandom_range(0, shadow_len - 1)] : $urandom;
      3: return 32'($urandom_range(0, 7)) - 32'd4;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_beat(row_t r);
    op <= r.op;
    data <= r.data;
    match_value <= r.match_value;
    position <= r.position;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    // accepted at this edge
    predict_list_op(r.op, r.data, r.match_value, r.position);
    if (r.known && (expected_beats[$].status !== r.status ||
                    expected_beats[$].count !== r.count)) begin
      errors++;
      if (errors <= 10)
        $display("directed row op %0d: exp status %0d count %0d, got %0d %0d", r.op,
                 r.status, r.count, expected_beats[$].status, expected_beats[$].count);
    end
    while (!no_idle && $urandom_range(0, 99) < 31) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // receiver side
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_beats.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected beat status %0d count %0d", status, count);
        end else begin
          beat_t e;
          e = expected_beats.pop_front();
          if (status !== e.status || element !== e.element || count !== e.count ||
              last !== e.last) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: exp st %0d el %0d cnt %0d last %0b, got %0d %0d %0d %0b",
                       e.status, $signed(e.element), e.count, e.last, status, element,
                       count, last);
          end
        end
      end
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        out_ready <= 1'b0;
      end else
        out_ready <= no_idle || $urandom_range(0, 99) >= 31;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  row_t directed [$];

  initial begin
    row_t r;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // empty list cases, then inserts, deletes, sort, read-out and no-ops on a short list
    directed.push_back('{OP_POP_FRONT, 0, 0, 0, 1, ST_EMPTY, 0});
    directed.push_back('{OP_POP_BACK, 0, 0, 0, 1, ST_EMPTY, 0});
    directed.push_back('{OP_DELETE_MATCH, 0, 0, 0, 1, ST_EMPTY, 0});
    directed.push_back('{OP_DELETE_AT, 0, 0, 0, 1, ST_EMPTY, 0});
    directed.push_back('{OP_SORT, 0, 0, 0, 1, ST_EMPTY, 0});
    directed.push_back('{OP_READ_OUT, 0, 0, 0, 1, ST_EMPTY, 0});
    directed.push_back('{OP_INSERT_AFTER, 5, 0, 0, 1, ST_NOTFOUND, 0});
    directed.push_back('{OP_INSERT_AT, 5, 0, 1, 1, ST_BADPOS, 0});
    directed.push_back('{OP_PUSH_BACK, 32'h7fff_ffff, 0, 0, 1, ST_OK, 1});
    directed.push_back('{OP_PUSH_FRONT, 32'h8000_0000, 0, 0, 1, ST_OK, 2});
    directed.push_back('{OP_INSERT_AT, 32'hffff_ffff, 0, 2, 1, ST_OK, 3});
    directed.push_back('{OP_INSERT_AFTER, 7, 32'h8000_0000, 0, 1, ST_OK, 4});
    directed.push_back('{OP_DELETE_AT, 0, 0, 4, 1, ST_BADPOS, 4});
    directed.push_back('{OP_DELETE_MATCH, 0, 32'h1234, 0, 1, ST_NOTFOUND, 4});
    directed.push_back('{OP_READ_OUT, 0, 0, 0, 0, 0, 0});
    directed.push_back('{OP_SORT, 0, 0, 0, 0, 0, 0});
    directed.push_back('{OP_READ_OUT, 0, 0, 0, 0, 0, 0});
    directed.push_back('{OP_DELETE_MATCH, 0, 32'h7fff_ffff, 0, 1, ST_OK, 3});
    directed.push_back('{OP_NOP_A, 0, 0, 0, 1, ST_OK, 3});
    directed.push_back('{OP_NOP_F, 32'hffff_ffff, 32'hffff_ffff, 7'h7f, 1, ST_OK, 3});
    directed.push_back('{OP_DELETE_AT, 0, 0, 7'h7f, 1, ST_BADPOS, 3});
    directed.push_back('{OP_POP_BACK, 0, 0, 0, 1, ST_OK, 2});
    directed.push_back('{OP_POP_FRONT, 0, 0, 0, 1, ST_OK, 1});
    foreach (directed[i]) send_beat(directed[i]);

    // fill to full, then the full cases, a stall while full, a sort and a read-out
    no_idle = 1'b1;
    while (shadow_len < DEPTH) send_beat('{OP_PUSH_BACK, $urandom, 0, 0, 0, 0, 0});
    send_beat('{OP_PUSH_FRONT, 1, 0, 0, 1, ST_FULL, 7'(DEPTH)});
    send_beat('{OP_INSERT_AT, 1, 0, 7'h7f, 1, ST_FULL, 7'(DEPTH)});
    send_beat('{OP_INSERT_AFTER, 1, 32'h5a5a, 0, 1, ST_FULL, 7'(DEPTH)});
    hold_off = 400;
    for (int i = 0; i < 12; i++) send_beat('{OP_READ_OUT, 0, 0, 0, 0, 0, 0});
    send_beat('{OP_SORT, 0, 0, 0, 0, 0, 0});
    send_beat('{OP_READ_OUT, 0, 0, 0, 0, 0, 0});
    no_idle = 1'b0;

    for (int n = 0; n < 260; n++) begin
      no_idle = n >= 120 && n < 170;
      r.known = 1'b0;
      r.status = '0;
      r.count = '0;
      r.data = pick_value();
      r.match_value = pick_value();
      r.position = $urandom_range(0, 9) == 0 ? 7'($urandom) :
                   7'($urandom_range(0, shadow_len + 1));
      case ($urandom_range(0, 19))
        0, 1, 2: r.op = shadow_len < 20 ? OP_PUSH_BACK : OP_POP_BACK;
        3, 4: r.op = OP_PUSH_FRONT;
        5, 6: r.op = OP_INSERT_AT;
        7, 8: r.op = OP_INSERT_AFTER;
        9: r.op = OP_POP_FRONT;
        10: r.op = OP_POP_BACK;
        11, 12: r.op = OP_DELETE_MATCH;
        13, 14: r.op = OP_DELETE_AT;
        15: r.op = OP_SORT;
        16, 17: r.op = OP_READ_OUT;
        18: r.op = 4'($urandom_range(10, 15));
        default: r.op = 4'($urandom_range(0, 9));
      endcase
      send_beat(r);
    end
    in_valid <= 1'b0;

    while (expected_beats.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (errors == 0 && expected_beats.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end
endmodule
